### design/c3f_pkg.sv
// Shared types, filter coefficients and fixed widths of the 3x3 five-filter convolution.
package c3f_pkg;

  localparam int NUM_CHAN   = 5;
  localparam int NUM_TAPS   = 9;
  localparam int PIX_W      = 8;
  localparam int WT_W       = 13;
  localparam int BIAS_W     = 17;
  localparam int PROD_W     = 22;
  localparam int ACC_W      = 24;
  localparam int OUT_W      = 16;
  localparam int POS_W      = 5;
  localparam int RND_SHIFT  = 8;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [WT_W-1:0]   wt_t;
  typedef logic signed [BIAS_W-1:0] bias_t;
  typedef logic signed [OUT_W-1:0]  chan_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             frame_end;
  } tag_t;

  // Weights are stored in window order: top row first, left column first.
  localparam wt_t WT [NUM_CHAN][NUM_TAPS] = '{
    '{ 13'sd1143,  13'sd1454,  13'sd1196,  13'sd1127,  13'sd2848,
       13'sd2534,  13'sd169,   13'sd2395,  13'sd1919 },
    '{ 13'sd190,   13'sd1955,  13'sd28,    13'sd615,   13'sd1577,
      -13'sd237,  -13'sd602,  -13'sd1877,  13'sd526 },
    '{ 13'sd763,   13'sd1081,  13'sd725,  -13'sd925,   13'sd501,
       13'sd1258, -13'sd2291,  13'sd1407,  13'sd989 },
    '{ 13'sd496,  -13'sd1267, -13'sd1707, -13'sd916,   13'sd1836,
       13'sd1712,  13'sd54,   -13'sd326,   13'sd1236 },
    '{ 13'sd2167,  13'sd522,  -13'sd833,   13'sd1554,  13'sd1341,
      -13'sd783,   13'sd1282,  13'sd600,   13'sd1747 }
  };

  localparam bias_t BIAS [NUM_CHAN] = '{
    17'sd6484, -17'sd2043, 17'sd57127, -17'sd1460, -17'sd7053
  };

endpackage

### design/c3f_if.sv
// Valid/ready channel interfaces for pixel requests and filter result requests.
interface c3f_in_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           pixel;
  logic                 frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface c3f_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   chan0;
  logic signed [15:0]   chan1;
  logic signed [15:0]   chan2;
  logic signed [15:0]   chan3;
  logic signed [15:0]   chan4;
  logic [4:0]           out_row;
  logic [4:0]           out_col;
  logic                 frame_end;

  modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                  output chan4, output out_row, output out_col, output frame_end,
                  input ready);
  modport sink   (input valid, input chan0, input chan1, input chan2, input chan3,
                  input chan4, input out_row, input out_col, input frame_end,
                  output ready);
endinterface

### design/c3f_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module c3f_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 28
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/c3f_mac.sv
// Pipelined five-filter multiply-accumulate with rounding and saturation to Q3.12.
module c3f_mac (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  c3f_pkg::pix_t              win [c3f_pkg::NUM_TAPS],
  input  c3f_pkg::tag_t              in_tag,
  output logic                       out_valid,
  output c3f_pkg::chan_t             out_chan [c3f_pkg::NUM_CHAN],
  output c3f_pkg::tag_t              out_tag
);
  import c3f_pkg::*;

  localparam int SUM_W    = ACC_W + 1;
  localparam int SH_W     = SUM_W - RND_SHIFT;
  localparam int RND_HALF = 1 << (RND_SHIFT - 1);
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-(2 ** (OUT_W - 1)));

  logic signed [PROD_W-1:0] prod_r [NUM_CHAN][NUM_TAPS];
  logic signed [ACC_W-1:0]  row_r  [NUM_CHAN][3];
  logic signed [ACC_W-1:0]  tot_r  [NUM_CHAN];
  chan_t                    q_nxt  [NUM_CHAN];
  chan_t                    q_r    [NUM_CHAN];

  logic p_valid_r, s_valid_r, t_valid_r, q_valid_r;
  tag_t p_tag_r, s_tag_r, t_tag_r, q_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
      t_valid_r <= 1'b0;
      q_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= in_valid;
      s_valid_r <= p_valid_r;
      t_valid_r <= s_valid_r;
      q_valid_r <= t_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_tag_r <= in_tag;
      s_tag_r <= p_tag_r;
      t_tag_r <= s_tag_r;
      q_tag_r <= t_tag_r;
      for (int k = 0; k < NUM_CHAN; k++) begin
        for (int i = 0; i < NUM_TAPS; i++) begin
          prod_r[k][i] <= $signed({{(PROD_W - PIX_W){1'b0}}, win[i]}) * PROD_W'(WT[k][i]);
        end
        for (int j = 0; j < 3; j++) begin
          row_r[k][j] <= ACC_W'(prod_r[k][3*j]) + ACC_W'(prod_r[k][3*j+1])
                       + ACC_W'(prod_r[k][3*j+2]);
        end
        tot_r[k] <= row_r[k][0] + row_r[k][1] + row_r[k][2] + ACC_W'(BIAS[k]);
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  // Round half up, floor toward minus infinity, then clamp to 16 bits.
  always_comb begin
    logic signed [SUM_W-1:0] biased;
    logic signed [SH_W-1:0]  shifted;
    for (int k = 0; k < NUM_CHAN; k++) begin
      biased  = SUM_W'(tot_r[k]) + SUM_W'(RND_HALF);
      shifted = $signed(biased[SUM_W-1:RND_SHIFT]);
      if (shifted > SAT_HI) begin
        q_nxt[k] = SAT_HI[OUT_W-1:0];
      end else if (shifted < SAT_LO) begin
        q_nxt[k] = SAT_LO[OUT_W-1:0];
      end else begin
        q_nxt[k] = shifted[OUT_W-1:0];
      end
    end
  end

  assign out_valid = q_valid_r;
  assign out_tag   = q_tag_r;
  assign out_chan  = q_r;

endmodule

### design/conv3x3_five_filter_layer.sv
// Top level: line-buffered 3x3 window feeding five fixed convolution filters.
// Path: line RAM stage, window, then MAC product, row-sum, total and result registers.
// Throughput: one pixel per cycle; the single line RAM is read and written once per pixel.
// Back-pressure: a stalled output holds the whole pipeline and drops in_ch.ready.
// Reset clears counters, window and valid bits; the line RAM is not cleared.
module conv3x3_five_filter_layer #(
  parameter int IMG_WIDTH  = 28,
  parameter int IMG_HEIGHT = 28
) (
  input  logic      clk,
  input  logic      rst_n,
  c3f_in_if.sink    in_ch,
  c3f_out_if.source out_ch
);
  import c3f_pkg::*;

  localparam int CW = $clog2(IMG_WIDTH);
  localparam int RW = $clog2(IMG_HEIGHT);
  localparam int LW = 2 * PIX_W;

  logic          en;
  logic          in_fire;

  logic [CW-1:0] col_r, col_nxt, col_eff;
  logic [RW-1:0] row_r, row_nxt, row_eff;
  logic [31:0]   col_m2, row_m2;
  logic          emit;
  tag_t          tag;

  logic          s1_valid_r;
  logic          s1_emit_r;
  logic          s1_fwd_r;
  pix_t          s1_px_r;
  logic [CW-1:0] s1_col_r;
  tag_t          s1_tag_r;
  logic [LW-1:0] fwd_data_r;

  logic          ram_we;
  logic [LW-1:0] ram_wdata;
  logic [LW-1:0] ram_rdata;
  logic [LW-1:0] line;

  pix_t          win_r [3][3];
  pix_t          win_flat [NUM_TAPS];
  logic          w_valid_r;
  tag_t          w_tag_r;

  logic          mac_valid;
  chan_t         mac_chan [NUM_CHAN];
  tag_t          mac_tag;

  assign en          = !mac_valid || out_ch.ready;
  assign in_ch.ready = en;
  assign in_fire     = in_ch.valid && en;

  always_comb begin
    col_eff = in_ch.frame_start ? '0 : col_r;
    row_eff = in_ch.frame_start ? '0 : row_r;
    if (col_eff == CW'(IMG_WIDTH - 1)) begin
      col_nxt = '0;
      row_nxt = (row_eff == RW'(IMG_HEIGHT - 1)) ? '0 : row_eff + RW'(1);
    end else begin
      col_nxt = col_eff + CW'(1);
      row_nxt = row_eff;
    end
    col_m2        = 32'(col_eff) - 32'd2;
    row_m2        = 32'(row_eff) - 32'd2;
    emit          = (row_eff >= RW'(2)) && (col_eff >= CW'(2));
    tag.row       = row_m2[POS_W-1:0];
    tag.col       = col_m2[POS_W-1:0];
    tag.frame_end = (row_eff == RW'(IMG_HEIGHT - 1)) && (col_eff == CW'(IMG_WIDTH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (en) begin
        s1_valid_r <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r    <= in_ch.pixel;
      s1_col_r   <= col_eff;
      s1_emit_r  <= emit;
      s1_tag_r   <= tag;
      s1_fwd_r   <= ram_we && (s1_col_r == col_eff);
      fwd_data_r <= ram_wdata;
    end
  end

  // Each RAM word holds the older row pixel in the upper byte and the newer in the lower.
  assign line      = s1_fwd_r ? fwd_data_r : ram_rdata;
  assign ram_we    = s1_valid_r && en;
  assign ram_wdata = {line[PIX_W-1:0], s1_px_r};

  c3f_ram #(
    .WIDTH (LW),
    .DEPTH (IMG_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (col_eff),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (en) begin
      w_valid_r <= s1_valid_r && s1_emit_r;
      if (s1_valid_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= line[LW-1:PIX_W];
        win_r[1][2] <= line[PIX_W-1:0];
        win_r[2][2] <= s1_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_tag_r <= s1_tag_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_flat[3*r+c] = win_r[r][c];
      end
    end
  end

  c3f_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (w_valid_r),
    .win       (win_flat),
    .in_tag    (w_tag_r),
    .out_valid (mac_valid),
    .out_chan  (mac_chan),
    .out_tag   (mac_tag)
  );

  assign out_ch.valid     = mac_valid;
  assign out_ch.chan0     = mac_chan[0];
  assign out_ch.chan1     = mac_chan[1];
  assign out_ch.chan2     = mac_chan[2];
  assign out_ch.chan3     = mac_chan[3];
  assign out_ch.chan4     = mac_chan[4];
  assign out_ch.out_row   = mac_tag.row;
  assign out_ch.out_col   = mac_tag.col;
  assign out_ch.frame_end = mac_tag.frame_end;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while a result is stalled");

  a_fire_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted pixel did not reach the line RAM stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !en |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_px_r))
    else $error("line RAM stage changed while stalled");

endmodule
